// File: src/assert_macros.svh
// Assertion helpers shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");

// Checks that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition occurred");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: src/rcpmq_pkg.sv
`default_nettype none

package rcpmq_pkg;

    // Field types.
    typedef logic [11:0]        pulse_t;
    typedef logic signed [15:0] cmd_t;
    typedef logic signed [7:0]  offset_t;
    typedef logic [15:0]        ratio_t;
    typedef logic [19:0]        mag_t;
    typedef logic [2:0]         cfg_index_t;
    typedef logic [15:0]        cfg_data_t;

    // Pulse bands in microseconds.
    localparam pulse_t PULSE_MIN    = 12'd800;
    localparam pulse_t PULSE_MAX    = 12'd2200;
    localparam pulse_t SAFE_LOW     = 12'd1600;
    localparam pulse_t AUTO_HIGH    = 12'd1400;
    localparam pulse_t CENTRE_STICK = 12'd1500;
    localparam pulse_t CENTRE_ENG   = 12'd1000;

    // Qualifying frame count for a mode change.
    localparam logic [1:0] QUALIFY = 2'd3;

    // Slots of the held pulse store, in input field order.
    localparam int HELD_RUD  = 0;
    localparam int HELD_MODE = 1;
    localparam int HELD_AIL  = 2;
    localparam int HELD_ELE  = 3;
    localparam int HELD_ENG  = 4;
    localparam int NUM_HELD  = 5;

    // Stick channels, in command and register order.
    localparam logic [1:0] CH_AIL = 2'd0;
    localparam logic [1:0] CH_ELE = 2'd1;
    localparam logic [1:0] CH_ENG = 2'd2;
    localparam logic [1:0] CH_RUD = 2'd3;
    localparam int NUM_CH = 4;

    // Register map: offsets first, then ratios; bit 2 selects the bank.
    localparam cfg_index_t REG_AIL_OFFSET = 3'd0;
    localparam cfg_index_t REG_ELE_OFFSET = 3'd1;
    localparam cfg_index_t REG_ENG_OFFSET = 3'd2;
    localparam cfg_index_t REG_RUD_OFFSET = 3'd3;
    localparam cfg_index_t REG_AIL_RATIO  = 3'd4;
    localparam cfg_index_t REG_ELE_RATIO  = 3'd5;
    localparam cfg_index_t REG_ENG_RATIO  = 3'd6;
    localparam cfg_index_t REG_RUD_RATIO  = 3'd7;

    localparam offset_t OFFSET_RESET = 8'sd0;
    localparam ratio_t  RATIO_RESET  = 16'd256;

    // Divider length: one quotient bit per cycle.
    localparam int DIV_STEPS = 20;

    localparam cmd_t CMD_MAX = 16'sh7FFF;
    localparam cmd_t CMD_MIN = -16'sh8000;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Mode qualifier status.
    typedef struct packed {
        logic safe;
        logic assist;
        logic save;
    } mode_stat_t;

    // True for a width that may be stored.
    function automatic logic pulse_in_band(input pulse_t p);
        return (p >= PULSE_MIN) && (p <= PULSE_MAX);
    endfunction

endpackage

`default_nettype wire

// File: src/rcpmq_if.sv
`default_nettype none

// Frame channel: one transaction carries the five pulse widths.
interface rcpmq_frame_if;
    import rcpmq_pkg::*;

    logic   valid;
    logic   ready;
    pulse_t pulse_rud;
    pulse_t pulse_mode;
    pulse_t pulse_ail;
    pulse_t pulse_ele;
    pulse_t pulse_eng;

    modport source (
        output valid, pulse_rud, pulse_mode, pulse_ail, pulse_ele, pulse_eng,
        input  ready
    );
    modport sink (
        input  valid, pulse_rud, pulse_mode, pulse_ail, pulse_ele, pulse_eng,
        output ready
    );
endinterface

// Result channel: one transaction per frame.
interface rcpmq_result_if;
    import rcpmq_pkg::*;

    logic valid;
    logic ready;
    cmd_t ail_cmd;
    cmd_t ele_cmd;
    cmd_t eng_cmd;
    cmd_t rud_cmd;
    logic safe_active;
    logic save_request;

    modport source (
        output valid, ail_cmd, ele_cmd, eng_cmd, rud_cmd, safe_active, save_request,
        input  ready
    );
    modport sink (
        input  valid, ail_cmd, ele_cmd, eng_cmd, rud_cmd, safe_active, save_request,
        output ready
    );
endinterface

// Configuration write channel.
interface rcpmq_cfg_if;
    import rcpmq_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// File: src/rc_pulse_mode_qualifier.sv
// RC pulse mode qualifier. Each frame transaction carries five pulse widths in
// microseconds; widths from 800 to 2200 are held, others keep the last held value.
// The held mode channel qualifies safe mode (three frames at 1600-2200) and the
// return to assisted flight (three frames at 800-1400), which raises save_request
// once and enables assist. While assist is on and safe mode is off, each stick
// channel gives (held - centre - 10*offset)*256/ratio, truncated toward zero and
// saturated to 16 bits; otherwise all commands are zero. The four quotients come
// from one shared restoring divider that retires one quotient bit per cycle,
// taking the channels in turn; a gated frame does not use the divider. A new
// frame is taken once the previous result has been loaded into the output
// register, even while that result still waits there for the sink.
// Configuration writes are accepted in any cycle and must only be issued while
// the block is idle.
`default_nettype none

`include "assert_macros.svh"

module rc_pulse_mode_qualifier (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rcpmq_frame_if.sink    frame,
    rcpmq_result_if.source result,
    rcpmq_cfg_if.sink      cfg
);
    import rcpmq_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    pulse_t  held_reg [NUM_HELD];
    pulse_t  in_pulse [NUM_HELD];
    offset_t offset_reg [NUM_CH];
    ratio_t  ratio_reg [NUM_CH];
    cmd_t    cmd_reg [NUM_CH];
    cmd_t    out_cmd_reg [NUM_CH];
    logic    out_valid_reg;
    logic    out_safe_reg;
    logic    out_save_reg;
    logic    neg_reg;
    logic    zero_reg;

    logic         frame_take;
    logic         out_load;
    logic         gate;
    logic         div_start;
    logic         cmd_store;
    cmd_t         cmd_value;
    pulse_t       mode_pulse;
    pulse_t       sel_held;
    pulse_t       sel_centre;
    offset_t      sel_offset;
    logic [13:0]  off_ext;
    logic [13:0]  off_x10;
    logic [13:0]  diff;
    logic [13:0]  diff_abs;
    mag_t         dividend;
    mag_t         quotient;
    div_stat_t    div_stat;
    mode_stat_t   mode_stat;

    // Frame handshake.
    assign frame.ready = (state_reg == S_IDLE);
    assign frame_take  = frame.valid && frame.ready;
    assign cfg.ready   = 1'b1;

    assign in_pulse[HELD_RUD]  = frame.pulse_rud;
    assign in_pulse[HELD_MODE] = frame.pulse_mode;
    assign in_pulse[HELD_AIL]  = frame.pulse_ail;
    assign in_pulse[HELD_ELE]  = frame.pulse_ele;
    assign in_pulse[HELD_ENG]  = frame.pulse_eng;

    // Held widths: store only in-band pulses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_HELD; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else if (frame_take)
        begin
            for (int i = 0; i < NUM_HELD; i++)
            begin
                if (pulse_in_band(in_pulse[i]))
                begin
                    held_reg[i] <= in_pulse[i];
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                offset_reg[i] <= OFFSET_RESET;
                ratio_reg[i]  <= RATIO_RESET;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_AIL_OFFSET, REG_ELE_OFFSET, REG_ENG_OFFSET, REG_RUD_OFFSET:
                    offset_reg[cfg.index[1:0]] <= cfg.data[7:0];
                REG_AIL_RATIO, REG_ELE_RATIO, REG_ENG_RATIO, REG_RUD_RATIO:
                    ratio_reg[cfg.index[1:0]] <= cfg.data;
                default:
                    ;
            endcase
        end
    end

    // Mode qualifier sees the mode width as it will be held after this frame.
    assign mode_pulse = pulse_in_band(frame.pulse_mode) ? frame.pulse_mode
                                                        : held_reg[HELD_MODE];

    rcpmq_mode u_mode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (frame_take),
        .mode_pulse (mode_pulse),
        .stat       (mode_stat)
    );

    assign gate = mode_stat.assist && !mode_stat.safe;

    // Channel operand selection.
    always_comb
    begin
        case (ch_reg)
            CH_AIL:  sel_held = held_reg[HELD_AIL];
            CH_ELE:  sel_held = held_reg[HELD_ELE];
            CH_ENG:  sel_held = held_reg[HELD_ENG];
            CH_RUD:  sel_held = held_reg[HELD_RUD];
            default: sel_held = held_reg[HELD_AIL];
        endcase
    end

    assign sel_centre = (ch_reg == CH_ENG) ? CENTRE_ENG : CENTRE_STICK;
    assign sel_offset = offset_reg[ch_reg];

    // Numerator before the fixed shift by eight: held - centre - 10*offset.
    assign off_ext  = {{6{sel_offset[7]}}, sel_offset};
    assign off_x10  = (off_ext << 3) + (off_ext << 1);
    assign diff     = {2'b00, sel_held} - {2'b00, sel_centre} - off_x10;
    assign diff_abs = diff[13] ? (~diff + 14'd1) : diff;
    assign dividend = {diff_abs[11:0], 8'h00};

    assign div_start = (state_reg == S_LOAD) && gate;

    rcpmq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (ratio_reg[ch_reg]),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Sign and zero of the operand in flight.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg  <= diff[13];
            zero_reg <= (diff == '0);
        end
    end

    // Apply sign and saturate the magnitude quotient.
    always_comb
    begin
        if (zero_reg)
        begin
            cmd_value = '0;
        end
        else if (neg_reg)
        begin
            cmd_value = (quotient > 20'd32768) ? CMD_MIN : cmd_t'(~quotient[15:0] + 16'd1);
        end
        else
        begin
            cmd_value = (quotient > 20'd32767) ? CMD_MAX : cmd_t'(quotient[15:0]);
        end
    end

    // Sequencer: one channel at a time, through the shared divider while commands are enabled.
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd_store  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (frame_take)
                begin
                    ch_next    = CH_AIL;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (gate)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd_store  = 1'b1;
                    ch_next    = ch_reg + 2'd1;
                    state_next = (ch_reg == CH_RUD) ? S_DONE : S_LOAD;
                end
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    cmd_store  = 1'b1;
                    ch_next    = ch_reg + 2'd1;
                    state_next = (ch_reg == CH_RUD) ? S_DONE : S_LOAD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= CH_AIL;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // Per-channel command store.
    always_ff @(posedge clk)
    begin
        if (cmd_store)
        begin
            cmd_reg[ch_reg] <= gate ? cmd_value : '0;
        end
    end

    // Output register: holds a result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                out_cmd_reg[i] <= cmd_reg[i];
            end
            out_safe_reg <= mode_stat.safe;
            out_save_reg <= mode_stat.save;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.ail_cmd      = out_cmd_reg[CH_AIL];
    assign result.ele_cmd      = out_cmd_reg[CH_ELE];
    assign result.eng_cmd      = out_cmd_reg[CH_ENG];
    assign result.rud_cmd      = out_cmd_reg[CH_RUD];
    assign result.safe_active  = out_safe_reg;
    assign result.save_request = out_save_reg;

    // A divider result only arrives while the sequencer waits for it.
    `ASSERT_CLK(a_done_in_wait, clk, rst_n, div_stat.done |-> (state_reg == S_WAIT))
    // The divider is never restarted while it runs.
    `ASSERT_NEVER(a_no_restart, clk, rst_n, div_start && div_stat.busy)
    // An accepted frame closes the input until its work is through.
    `ASSERT_CLK(a_busy_after_take, clk, rst_n, frame_take |=> !frame.ready)
    // Safe mode forces all commands to zero and never comes with a save request.
    `ASSERT_CLK(a_safe_gated, clk, rst_n,
        (result.valid && result.safe_active) |->
            (result.ail_cmd == 16'sd0 && result.ele_cmd == 16'sd0 &&
             result.eng_cmd == 16'sd0 && result.rud_cmd == 16'sd0 &&
             !result.save_request))

endmodule

`default_nettype wire

// File: src/rcpmq_mode.sv
`default_nettype none

module rcpmq_mode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire rcpmq_pkg::pulse_t   mode_pulse,
    output rcpmq_pkg::mode_stat_t    stat
);
    import rcpmq_pkg::*;

    logic [1:0] safe_cnt_reg, safe_cnt_next;
    logic [1:0] auto_cnt_reg, auto_cnt_next;
    logic       safe_reg, safe_next;
    logic       assist_reg, assist_next;
    logic       save_reg, save_next;
    logic       in_safe_band;
    logic       in_auto_band;

    // Band decode of the held mode width.
    assign in_safe_band = (mode_pulse >= SAFE_LOW) && (mode_pulse <= PULSE_MAX);
    assign in_auto_band = (mode_pulse >= PULSE_MIN) && (mode_pulse <= AUTO_HIGH);

    // Saturating counters and the safe/assist decisions for one frame.
    always_comb
    begin
        safe_cnt_next = safe_cnt_reg;
        auto_cnt_next = auto_cnt_reg;
        safe_next     = safe_reg;
        assist_next   = assist_reg;
        save_next     = save_reg;
        if (step)
        begin
            if (in_safe_band)
            begin
                safe_cnt_next = (safe_cnt_reg == QUALIFY) ? QUALIFY : safe_cnt_reg + 2'd1;
                auto_cnt_next = 2'd0;
            end
            else if (in_auto_band)
            begin
                auto_cnt_next = (auto_cnt_reg == QUALIFY) ? QUALIFY : auto_cnt_reg + 2'd1;
                safe_cnt_next = 2'd0;
            end
            else
            begin
                safe_cnt_next = 2'd0;
                auto_cnt_next = 2'd0;
            end

            save_next = 1'b0;
            if (safe_cnt_next == QUALIFY)
            begin
                safe_next = 1'b1;
            end
            else if (auto_cnt_next == QUALIFY)
            begin
                if (safe_reg)
                begin
                    save_next   = 1'b1;
                    assist_next = 1'b1;
                end
                safe_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_cnt_reg <= 2'd0;
            auto_cnt_reg <= 2'd0;
            safe_reg     <= 1'b0;
            assist_reg   <= 1'b0;
            save_reg     <= 1'b0;
        end
        else
        begin
            safe_cnt_reg <= safe_cnt_next;
            auto_cnt_reg <= auto_cnt_next;
            safe_reg     <= safe_next;
            assist_reg   <= assist_next;
            save_reg     <= save_next;
        end
    end

    assign stat.safe   = safe_reg;
    assign stat.assist = assist_reg;
    assign stat.save   = save_reg;

endmodule

`default_nettype wire

// File: src/rcpmq_div.sv
`default_nettype none

module rcpmq_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire rcpmq_pkg::mag_t     dividend,
    input  wire rcpmq_pkg::ratio_t   divisor,
    output rcpmq_pkg::div_stat_t     stat,
    output rcpmq_pkg::mag_t          quotient
);
    import rcpmq_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      rem_reg, rem_next;
    mag_t             quo_reg, quo_next;
    ratio_t           dvs_reg, dvs_next;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[19]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[15:0] : trial[15:0];
            quo_next = {quo_reg[18:0], fits};
            cnt_next = cnt_reg + CNT_ONE;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire
